// ===== src/tp2cur_pkg.sv =====
// Shared widths, event codes, frame kinds and register indexes for the
// touchpad frame to cursor block. Depends on nothing.
`timescale 1ns / 1ps

package tp2cur_pkg;

  // Field widths of the event, result and configuration channels.
  localparam int TYPE_W      = 16;
  localparam int CODE_W      = 16;
  localparam int VALUE_W     = 32;
  localparam int KIND_W      = 3;
  localparam int SCALE_W     = 24;
  localparam int SCREEN_W    = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  // Touch position width and scale fraction bits.
  localparam int POS_BITS        = 16;
  localparam int SCALE_FRAC_BITS = 16;

  // Derived datapath widths.
  localparam int CURSOR_W = SCREEN_W + SCALE_FRAC_BITS;
  localparam int DELTA_W  = POS_BITS + 1;
  localparam int PROD_W   = DELTA_W + SCALE_W + 1;
  localparam int SUM_W    = PROD_W + 2;

  // Event types and codes.
  localparam logic [TYPE_W-1:0] TYPE_SYNC = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] TYPE_KEY  = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] TYPE_ABS  = TYPE_W'(3);

  localparam logic [CODE_W-1:0] CODE_REPORT = CODE_W'(0);
  localparam logic [CODE_W-1:0] AXIS_X      = CODE_W'(16'h0000);
  localparam logic [CODE_W-1:0] AXIS_Y      = CODE_W'(16'h0001);
  localparam logic [CODE_W-1:0] AXIS_MT_X   = CODE_W'(16'h0035);
  localparam logic [CODE_W-1:0] AXIS_MT_Y   = CODE_W'(16'h0036);
  localparam logic [CODE_W-1:0] KEY_LEFT    = CODE_W'(16'h0110);
  localparam logic [CODE_W-1:0] KEY_TOUCH   = CODE_W'(16'h014a);

  // Frame kinds.
  localparam logic [KIND_W-1:0] KIND_POS        = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_BTN_UP     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_BTN_DOWN   = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_TOUCH_UP   = KIND_W'(3);
  localparam logic [KIND_W-1:0] KIND_TOUCH_DOWN = KIND_W'(4);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_X_SCALE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_SCALE = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_W = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_H = CFG_INDEX_W'(3);

  // Register reset values: unity scale and a 1920 by 1080 screen.
  localparam logic [SCALE_W-1:0]  SCALE_RESET   = SCALE_W'(1) << SCALE_FRAC_BITS;
  localparam logic [SCREEN_W-1:0] PANEL_W_RESET = SCREEN_W'(1920);
  localparam logic [SCREEN_W-1:0] PANEL_H_RESET = SCREEN_W'(1080);

  // Limits of the touch position range, sign extended to the event value width.
  localparam logic signed [VALUE_W-1:0] POS_MAX_EXT =
    $signed({{(VALUE_W - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}});
  localparam logic signed [VALUE_W-1:0] POS_MIN_EXT = ~POS_MAX_EXT;

  // Saturate an event value to the signed touch position range.
  function automatic logic signed [POS_BITS-1:0] sat_pos(
    input logic signed [VALUE_W-1:0] v
  );
    logic signed [POS_BITS-1:0] r;
    if (v > POS_MAX_EXT) begin
      r = POS_MAX_EXT[POS_BITS-1:0];
    end else if (v < POS_MIN_EXT) begin
      r = POS_MIN_EXT[POS_BITS-1:0];
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  // Clamp a moved cursor to zero .. screen size in fixed point.
  function automatic logic [CURSOR_W-1:0] clamp_cursor(
    input logic signed [SUM_W-1:0] s,
    input logic [SCREEN_W-1:0]     screen
  );
    logic [CURSOR_W-1:0]     top;
    logic signed [SUM_W-1:0] top_ext;
    logic [CURSOR_W-1:0]     r;
    top     = {screen, {SCALE_FRAC_BITS{1'b0}}};
    top_ext = $signed(SUM_W'(top));
    if (s < $signed(SUM_W'(0))) begin
      r = '0;
    end else if (s > top_ext) begin
      r = top;
    end else begin
      r = s[CURSOR_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/tp2cur_if.sv =====
// Valid/ready channel interfaces for events, cursor results and register writes.
// Depends on tp2cur_pkg for the field widths.
`timescale 1ns / 1ps

// Input event channel.
interface tp2cur_evt_if;
  logic                                valid;
  logic                                ready;
  logic [tp2cur_pkg::TYPE_W-1:0]       ev_type;
  logic [tp2cur_pkg::CODE_W-1:0]       ev_code;
  logic signed [tp2cur_pkg::VALUE_W-1:0] ev_value;

  modport source (output valid, ev_type, ev_code, ev_value, input ready);
  modport sink (input valid, ev_type, ev_code, ev_value, output ready);
endinterface

// Result channel, one transfer per sync report.
interface tp2cur_res_if;
  logic                                   valid;
  logic                                   ready;
  logic [tp2cur_pkg::KIND_W-1:0]          frame_kind;
  logic signed [tp2cur_pkg::POS_BITS-1:0] touch_x;
  logic signed [tp2cur_pkg::POS_BITS-1:0] touch_y;
  logic [tp2cur_pkg::SCREEN_W-1:0]        cursor_x;
  logic [tp2cur_pkg::SCREEN_W-1:0]        cursor_y;

  modport source (output valid, frame_kind, touch_x, touch_y, cursor_x, cursor_y,
                  input ready);
  modport sink (input valid, frame_kind, touch_x, touch_y, cursor_x, cursor_y,
                output ready);
endinterface

// Register write channel.
interface tp2cur_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tp2cur_pkg::CFG_INDEX_W-1:0] index;
  logic [tp2cur_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/touchpad_frame_to_cursor.sv =====
// Top level of the touchpad event to cursor converter.
// Depends on tp2cur_pkg and the channel interfaces in tp2cur_if.sv.
`timescale 1ns / 1ps

// The block takes one event per clock cycle while its input is not held, and answers
// every sync report with one result that holds the frame kind, the latched touch
// position and the clamped cursor. An event is registered on transfer and handled in
// the next cycle unless it is a held sync report. The cycle time is set by the
// per-axis path from the touch delta through one 17 by 24 bit multiply, the cursor
// add and the clamp. A new event is still taken while a result waits in the output
// register; only a sync report that meets a full, stalled output register holds the
// input. The user must write the registers (scales unsigned Q8.16, screen size in
// pixels) only while idle; the block itself does not enforce this.
module touchpad_frame_to_cursor (
  input logic         clk,
  input logic         rst,
  tp2cur_evt_if.sink  evt,
  tp2cur_res_if.source res,
  tp2cur_cfg_if.sink  cfg
);

  // Configuration registers.
  logic [tp2cur_pkg::SCALE_W-1:0]  x_scale;
  logic [tp2cur_pkg::SCALE_W-1:0]  y_scale;
  logic [tp2cur_pkg::SCREEN_W-1:0] panel_w;
  logic [tp2cur_pkg::SCREEN_W-1:0] panel_h;

  // Input register.
  logic                                    in_valid;
  logic [tp2cur_pkg::TYPE_W-1:0]           in_type;
  logic [tp2cur_pkg::CODE_W-1:0]           in_code;
  logic signed [tp2cur_pkg::VALUE_W-1:0]   in_value;

  // Frame state.
  logic signed [tp2cur_pkg::POS_BITS-1:0] latched_x;
  logic signed [tp2cur_pkg::POS_BITS-1:0] latched_y;
  logic signed [tp2cur_pkg::POS_BITS-1:0] last_touch_x;
  logic signed [tp2cur_pkg::POS_BITS-1:0] last_touch_y;
  logic [tp2cur_pkg::CURSOR_W-1:0]        cursor_fx;
  logic [tp2cur_pkg::CURSOR_W-1:0]        cursor_fy;
  logic [tp2cur_pkg::KIND_W-1:0]          pending_kind;

  // Output register.
  logic                                   out_valid;
  logic [tp2cur_pkg::KIND_W-1:0]          out_kind;
  logic signed [tp2cur_pkg::POS_BITS-1:0] out_touch_x;
  logic signed [tp2cur_pkg::POS_BITS-1:0] out_touch_y;
  logic [tp2cur_pkg::SCREEN_W-1:0]        out_cursor_x;
  logic [tp2cur_pkg::SCREEN_W-1:0]        out_cursor_y;

  // Datapath signals.
  logic                                   is_sync;
  logic                                   is_abs;
  logic                                   is_key;
  logic                                   out_free;
  logic                                   step;
  logic                                   frame;
  logic                                   key_pressed;
  logic signed [tp2cur_pkg::DELTA_W-1:0]  dx;
  logic signed [tp2cur_pkg::DELTA_W-1:0]  dy;
  logic signed [tp2cur_pkg::PROD_W-1:0]   prod_x;
  logic signed [tp2cur_pkg::PROD_W-1:0]   prod_y;
  logic signed [tp2cur_pkg::SUM_W-1:0]    sum_x;
  logic signed [tp2cur_pkg::SUM_W-1:0]    sum_y;
  logic [tp2cur_pkg::CURSOR_W-1:0]        cursor_fx_next;
  logic [tp2cur_pkg::CURSOR_W-1:0]        cursor_fy_next;
  logic                                   moving;
  logic                                   reload_touch;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale <= tp2cur_pkg::SCALE_RESET;
      y_scale <= tp2cur_pkg::SCALE_RESET;
      panel_w <= tp2cur_pkg::PANEL_W_RESET;
      panel_h <= tp2cur_pkg::PANEL_H_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tp2cur_pkg::CFG_X_SCALE: x_scale <= cfg.data[tp2cur_pkg::SCALE_W-1:0];
        tp2cur_pkg::CFG_Y_SCALE: y_scale <= cfg.data[tp2cur_pkg::SCALE_W-1:0];
        tp2cur_pkg::CFG_PANEL_W: panel_w <= cfg.data[tp2cur_pkg::SCREEN_W-1:0];
        tp2cur_pkg::CFG_PANEL_H: panel_h <= cfg.data[tp2cur_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Event decode and flow control. Only a sync report needs room at the output.
  assign is_sync  = (in_type == tp2cur_pkg::TYPE_SYNC) && (in_code == tp2cur_pkg::CODE_REPORT);
  assign is_abs   = (in_type == tp2cur_pkg::TYPE_ABS);
  assign is_key   = (in_type == tp2cur_pkg::TYPE_KEY);
  assign out_free = !out_valid || res.ready;
  assign step     = in_valid && (!is_sync || out_free);
  assign frame    = step && is_sync;
  assign evt.ready = !in_valid || step;
  assign key_pressed = (in_value != '0);

  // Cursor move: scaled touch delta added to the cursor, then clamped.
  // Frames other than position frames only clamp.
  assign moving       = (pending_kind == tp2cur_pkg::KIND_POS);
  assign reload_touch = moving || (pending_kind == tp2cur_pkg::KIND_TOUCH_DOWN);

  always_comb begin
    dx     = tp2cur_pkg::DELTA_W'(latched_x) - tp2cur_pkg::DELTA_W'(last_touch_x);
    dy     = tp2cur_pkg::DELTA_W'(latched_y) - tp2cur_pkg::DELTA_W'(last_touch_y);
    prod_x = dx * $signed({1'b0, x_scale});
    prod_y = dy * $signed({1'b0, y_scale});
    sum_x  = $signed(tp2cur_pkg::SUM_W'(cursor_fx));
    sum_y  = $signed(tp2cur_pkg::SUM_W'(cursor_fy));
    if (moving) begin
      sum_x = sum_x + tp2cur_pkg::SUM_W'(prod_x);
      sum_y = sum_y + tp2cur_pkg::SUM_W'(prod_y);
    end
    cursor_fx_next = tp2cur_pkg::clamp_cursor(sum_x, panel_w);
    cursor_fy_next = tp2cur_pkg::clamp_cursor(sum_y, panel_h);
  end

  // Input register: loads on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
    if (evt.valid && evt.ready) begin
      in_type  <= evt.ev_type;
      in_code  <= evt.ev_code;
      in_value <= evt.ev_value;
    end
  end

  // Frame state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_x    <= '0;
      latched_y    <= '0;
      last_touch_x <= '0;
      last_touch_y <= '0;
      cursor_fx    <= '0;
      cursor_fy    <= '0;
      pending_kind <= tp2cur_pkg::KIND_POS;
    end else if (step) begin
      if (is_abs) begin
        if (in_code == tp2cur_pkg::AXIS_X || in_code == tp2cur_pkg::AXIS_MT_X) begin
          latched_x <= tp2cur_pkg::sat_pos(in_value);
        end else if (in_code == tp2cur_pkg::AXIS_Y || in_code == tp2cur_pkg::AXIS_MT_Y) begin
          latched_y <= tp2cur_pkg::sat_pos(in_value);
        end
      end else if (is_key) begin
        if (in_code == tp2cur_pkg::KEY_LEFT) begin
          pending_kind <= key_pressed ? tp2cur_pkg::KIND_BTN_DOWN : tp2cur_pkg::KIND_BTN_UP;
        end else if (in_code == tp2cur_pkg::KEY_TOUCH) begin
          pending_kind <= key_pressed ? tp2cur_pkg::KIND_TOUCH_DOWN
                                      : tp2cur_pkg::KIND_TOUCH_UP;
        end
      end else if (is_sync) begin
        cursor_fx    <= cursor_fx_next;
        cursor_fy    <= cursor_fy_next;
        pending_kind <= tp2cur_pkg::KIND_POS;
        if (reload_touch) begin
          last_touch_x <= latched_x;
          last_touch_y <= latched_y;
        end
      end
    end
  end

  // Output register: filled by a sync report, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (frame) begin
      out_kind     <= pending_kind;
      out_touch_x  <= latched_x;
      out_touch_y  <= latched_y;
      out_cursor_x <= cursor_fx_next[tp2cur_pkg::SCALE_FRAC_BITS +: tp2cur_pkg::SCREEN_W];
      out_cursor_y <= cursor_fy_next[tp2cur_pkg::SCALE_FRAC_BITS +: tp2cur_pkg::SCREEN_W];
    end
  end

  assign res.valid      = out_valid;
  assign res.frame_kind = out_kind;
  assign res.touch_x    = out_touch_x;
  assign res.touch_y    = out_touch_y;
  assign res.cursor_x   = out_cursor_x;
  assign res.cursor_y   = out_cursor_y;

endmodule
